// ===== src/pcr_pkg.sv =====
// Package: shared constants and types of the rectangle polygon clipper.
`timescale 1ns / 1ps
package pcr_pkg;

  // Configuration register indexes.
  localparam int unsigned CfgIdxBits = 3;
  localparam logic [CfgIdxBits-1:0] REG_X_MIN = 3'd0;
  localparam logic [CfgIdxBits-1:0] REG_Y_MIN = 3'd1;
  localparam logic [CfgIdxBits-1:0] REG_X_MAX = 3'd2;
  localparam logic [CfgIdxBits-1:0] REG_Y_MAX = 3'd3;

  localparam int NumStages = 4;

  // Window defaults after reset.
  localparam int ResetLow  = 100;
  localparam int ResetHigh = 300;

  // How one clip cell reads its boundary.
  typedef struct packed {
    logic use_y;    // boundary is on the y axis
    logic keep_ge;  // inside means coordinate >= boundary
  } stage_mode_t;

  localparam stage_mode_t MODE_LEFT   = '{use_y: 1'b0, keep_ge: 1'b1};
  localparam stage_mode_t MODE_BOTTOM = '{use_y: 1'b1, keep_ge: 1'b1};
  localparam stage_mode_t MODE_RIGHT  = '{use_y: 1'b0, keep_ge: 1'b0};
  localparam stage_mode_t MODE_TOP    = '{use_y: 1'b1, keep_ge: 1'b0};

endpackage

// ===== src/pcr_if.sv =====
// Interfaces: vertex input, clipped result and configuration write channels.
`timescale 1ns / 1ps
interface pcr_vtx_if #(parameter int W = 16);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] vert_x;
  logic signed [W-1:0] vert_y;
  logic                final_vertex;
  modport source (output valid, vert_x, vert_y, final_vertex, input ready);
  modport sink   (input valid, vert_x, vert_y, final_vertex, output ready);
endinterface

interface pcr_res_if #(parameter int W = 16);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] out_x;
  logic signed [W-1:0] out_y;
  logic                out_last;
  logic                all_clipped;
  modport source (output valid, out_x, out_y, out_last, all_clipped, input ready);
  modport sink   (input valid, out_x, out_y, out_last, all_clipped, output ready);
endinterface

interface pcr_cfg_if #(parameter int W = 16, parameter int IW = 3);
  logic          valid;
  logic          ready;
  logic [IW-1:0] index;
  logic [W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/polygon_clip_to_rectangle.sv =====
// Top level: rectangle polygon clipper, four clip cells in a row.
`timescale 1ns / 1ps
//
//  channel   dir  handshake                 payload
//  in_vtx    in   valid/ready               vert_x, vert_y, final_vertex
//  out_res   out  valid/ready               out_x, out_y, out_last, all_clipped
//  cfg_wr    in   valid/ready (always ready) index, data
//
//  A cell takes no new vertex until it has sent on all that the last one gave;
//  a crossing first runs through that cell's bit-serial divider (one quotient
//  bit per cycle). A final vertex adds a close transaction that walks the row
//  behind it. Reset is synchronous and active low; it clears control state
//  and loads the default window. Any cell stalls the cells before it when its
//  output is not taken.
module polygon_clip_to_rectangle #(
  parameter int COORD_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  pcr_vtx_if.sink    in_vtx,
  pcr_res_if.source  out_res,
  pcr_cfg_if.sink    cfg_wr
);
  import pcr_pkg::*;

  localparam int W = COORD_BITS;

  // Window registers.
  logic signed [W-1:0] x_min_r, y_min_r, x_max_r, y_max_r;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_min_r <= W'(ResetLow);
      y_min_r <= W'(ResetLow);
      x_max_r <= W'(ResetHigh);
      y_max_r <= W'(ResetHigh);
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        REG_X_MIN: x_min_r <= cfg_wr.data;
        REG_Y_MIN: y_min_r <= cfg_wr.data;
        REG_X_MAX: x_max_r <= cfg_wr.data;
        REG_Y_MAX: y_max_r <= cfg_wr.data;
        default: ;  // drop writes past the register list
      endcase
    end
  end

  // Front: turn an input transaction into a vertex token and, on the final
  // vertex, a close token right behind it.
  logic                f_valid_r, f_close_r, f_pend_r;
  logic signed [W-1:0] f_x_r, f_y_r;

  // Token links between cells: link k feeds cell k, the last feeds the hold.
  logic                tv [0:NumStages];
  logic                tr [0:NumStages];
  logic                tc [0:NumStages];
  logic signed [W-1:0] tx [0:NumStages];
  logic signed [W-1:0] ty [0:NumStages];

  assign in_vtx.ready = !f_valid_r;
  assign tv[0] = f_valid_r;
  assign tc[0] = f_close_r;
  assign tx[0] = f_x_r;
  assign ty[0] = f_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (in_vtx.valid && in_vtx.ready) begin
      f_valid_r <= 1'b1;
      f_close_r <= 1'b0;
      f_pend_r  <= in_vtx.final_vertex;
      f_x_r     <= in_vtx.vert_x;
      f_y_r     <= in_vtx.vert_y;
    end else if (f_valid_r && tr[0]) begin
      // Advance: the vertex went in, now send the close if one is pending.
      if (f_pend_r && !f_close_r) f_close_r <= 1'b1;
      else f_valid_r <= 1'b0;
    end
  end

  // Boundary order: left, bottom (y_min), right, top (y_max).
  stage_mode_t         modes [0:NumStages-1];
  logic signed [W-1:0] bounds [0:NumStages-1];

  assign modes[0] = MODE_LEFT;
  assign modes[1] = MODE_BOTTOM;
  assign modes[2] = MODE_RIGHT;
  assign modes[3] = MODE_TOP;
  assign bounds[0] = x_min_r;
  assign bounds[1] = y_min_r;
  assign bounds[2] = x_max_r;
  assign bounds[3] = y_max_r;

  for (genvar k = 0; k < NumStages; k++) begin : g_cell
    pcr_cell #(.W(W)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .mode    (modes[k]),
      .bound   (bounds[k]),
      .i_valid (tv[k]),
      .i_ready (tr[k]),
      .i_close (tc[k]),
      .i_x     (tx[k]),
      .i_y     (ty[k]),
      .o_valid (tv[k+1]),
      .o_ready (tr[k+1]),
      .o_close (tc[k+1]),
      .o_x     (tx[k+1]),
      .o_y     (ty[k+1])
    );
  end

  // Hold the latest clipped vertex; release it marked on close.
  pcr_hold #(.W(W)) u_hold (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (tv[NumStages]),
    .i_ready (tr[NumStages]),
    .i_close (tc[NumStages]),
    .i_x     (tx[NumStages]),
    .i_y     (ty[NumStages]),
    .res     (out_res)
  );

endmodule

// ===== src/pcr_cell.sv =====
// Clip cell: clips the vertex stream against one window boundary.
`timescale 1ns / 1ps
module pcr_cell #(
  parameter int W = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pcr_pkg::stage_mode_t mode,
  input  logic signed [W-1:0] bound,
  input  logic                i_valid,
  output logic                i_ready,
  input  logic                i_close,
  input  logic signed [W-1:0] i_x,
  input  logic signed [W-1:0] i_y,
  output logic                o_valid,
  input  logic                o_ready,
  output logic                o_close,
  output logic signed [W-1:0] o_x,
  output logic signed [W-1:0] o_y
);
  import pcr_pkg::*;

  localparam int CntBits = $clog2(W + 2);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_DIV, S_FIX, S_XOUT, S_EOUT, S_COUT
  } state_t;

  state_t              state_r;
  logic                seen_r;
  logic signed [W-1:0] fx_r, fy_r, px_r, py_r, ex_r, ey_r;
  logic                end_in_r, close_r, neg_r;
  logic signed [W:0]   o1_r;
  logic [W:0]          mdob_r, mt_r, mda_r;
  logic [W:0]          rem_r, lo_r;
  logic [CntBits-1:0]  cnt_r;
  logic                oclose_r;
  logic signed [W-1:0] ox_r, oy_r;

  // Edge setup from the start point (previous) and the end point.
  logic signed [W-1:0] e_x, e_y;
  logic                in1, in2;
  logic signed [W:0]   a1, a2, o1, o2, bw, da, tt, dob;
  logic [W:0]          mda, mt, mdob;
  logic                neg;
  logic [2*W+1:0]      prod;
  logic [W+1:0]        rem2;
  logic                ge;
  logic signed [W+2:0] base, base_fix;

  function automatic logic is_in(logic signed [W-1:0] v, logic signed [W-1:0] b,
                                 logic keep_ge);
    is_in = keep_ge ? (v >= b) : (v <= b);
  endfunction

  function automatic logic [W:0] mag(logic signed [W:0] v);
    mag = v[W] ? (W+1)'(-v) : v;
  endfunction

  always_comb begin
    e_x  = i_close ? fx_r : i_x;
    e_y  = i_close ? fy_r : i_y;
    in1  = is_in(mode.use_y ? py_r : px_r, bound, mode.keep_ge);
    in2  = is_in(mode.use_y ? e_y : e_x, bound, mode.keep_ge);
    a1   = (W+1)'(mode.use_y ? py_r : px_r);
    a2   = (W+1)'(mode.use_y ? e_y : e_x);
    o1   = (W+1)'(mode.use_y ? px_r : py_r);
    o2   = (W+1)'(mode.use_y ? e_x : e_y);
    bw   = (W+1)'(bound);
    da   = a2 - a1;
    tt   = bw - a1;
    dob  = o2 - o1;
    mda  = mag(da);
    mt   = mag(tt);
    mdob = mag(dob);
    neg  = (dob[W] != tt[W]) != da[W];
    prod = (2*W+2)'(mdob_r) * (2*W+2)'(mt_r);
    rem2 = {rem_r, lo_r[W]};
    ge   = rem2 >= {1'b0, mda_r};
    base = neg_r ? (W+3)'(o1_r) - $signed({2'b00, lo_r})
                 : (W+3)'(o1_r) + $signed({2'b00, lo_r});
    base_fix = base;
    if (rem_r != '0) begin
      if (!neg_r && base < 0) base_fix = base + (W+3)'(1);
      if (neg_r && base > 0) base_fix = base - (W+3)'(1);
    end
  end

  assign i_ready = (state_r == S_IDLE);
  assign o_valid = (state_r == S_XOUT) || (state_r == S_EOUT) || (state_r == S_COUT);
  assign o_close = oclose_r;
  assign o_x     = ox_r;
  assign o_y     = oy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      seen_r  <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (i_valid) begin
            close_r  <= i_close;
            ex_r     <= e_x;
            ey_r     <= e_y;
            end_in_r <= in2;
            o1_r     <= o1;
            mdob_r   <= mdob;
            mt_r     <= mt;
            mda_r    <= mda;
            neg_r    <= neg;
            if (i_close) begin
              seen_r <= 1'b0;
            end else begin
              px_r <= i_x;
              py_r <= i_y;
              if (!seen_r) begin
                fx_r   <= i_x;
                fy_r   <= i_y;
                seen_r <= 1'b1;
              end
            end
            if (!seen_r) begin
              // First vertex: store only. Close with nothing held: pass on.
              if (i_close) begin
                oclose_r <= 1'b1;
                state_r  <= S_COUT;
              end
            end else if (in1 != in2) begin
              state_r <= S_MUL;
            end else if (in2) begin
              oclose_r <= 1'b0;
              ox_r     <= e_x;
              oy_r     <= e_y;
              state_r  <= S_EOUT;
            end else if (i_close) begin
              oclose_r <= 1'b1;
              state_r  <= S_COUT;
            end
          end
        end
        S_MUL: begin
          rem_r   <= prod[2*W+1:W+1];
          lo_r    <= prod[W:0];
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          // Restoring division, one quotient bit per cycle shifted into lo_r.
          rem_r <= ge ? (W+1)'(rem2 - {1'b0, mda_r}) : rem2[W:0];
          lo_r  <= {lo_r[W-1:0], ge};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CntBits'(W)) state_r <= S_FIX;
        end
        S_FIX: begin
          oclose_r <= 1'b0;
          ox_r     <= mode.use_y ? base_fix[W-1:0] : bound;
          oy_r     <= mode.use_y ? bound : base_fix[W-1:0];
          state_r  <= S_XOUT;
        end
        S_XOUT: begin
          if (o_ready) begin
            if (end_in_r) begin
              ox_r    <= ex_r;
              oy_r    <= ey_r;
              state_r <= S_EOUT;
            end else if (close_r) begin
              oclose_r <= 1'b1;
              state_r  <= S_COUT;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_EOUT: begin
          if (o_ready) begin
            if (close_r) begin
              oclose_r <= 1'b1;
              state_r  <= S_COUT;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_COUT: begin
          if (o_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/pcr_hold.sv =====
// Output hold: delays clipped vertices by one so the last can be marked.
`timescale 1ns / 1ps
module pcr_hold #(
  parameter int W = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                i_valid,
  output logic                i_ready,
  input  logic                i_close,
  input  logic signed [W-1:0] i_x,
  input  logic signed [W-1:0] i_y,
  pcr_res_if.source           res
);
  import pcr_pkg::*;

  logic                held_r, ov_r, last_r, empty_r;
  logic signed [W-1:0] hx_r, hy_r, ox_r, oy_r;
  logic                ov_nxt;

  assign i_ready         = !ov_r || res.ready;
  assign res.valid       = ov_r;
  assign res.out_x       = ox_r;
  assign res.out_y       = oy_r;
  assign res.out_last    = last_r;
  assign res.all_clipped = empty_r;

  always_comb begin
    ov_nxt = ov_r && !res.ready;
    if (i_valid && i_ready && (i_close || held_r)) ov_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      if (i_valid && i_ready) begin
        if (i_close) begin
          last_r  <= 1'b1;
          empty_r <= !held_r;
          ox_r    <= held_r ? hx_r : '0;
          oy_r    <= held_r ? hy_r : '0;
          held_r  <= 1'b0;
        end else begin
          if (held_r) begin
            last_r  <= 1'b0;
            empty_r <= 1'b0;
            ox_r    <= hx_r;
            oy_r    <= hy_r;
          end
          hx_r   <= i_x;
          hy_r   <= i_y;
          held_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== tb/sv/pcr_clip_checker.sv =====
// Checker: predicts clipped polygon vertices and compares them with the block's results.
`timescale 1ns / 1ps
module pcr_clip_checker (
  input  logic clk,
  input  logic rst_n,
  pcr_vtx_if   vtx,
  pcr_res_if   res,
  pcr_cfg_if   cfg,
  output int   fail_count,
  output int   expected_left,
  output int   vertices_taken,
  output int   results_taken,
  output int   empty_results
);
  import pcr_pkg::*;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               last;
    logic               empty;
  } clip_vertex_t;

  clip_vertex_t clipped_q[$];

  longint win_x_lo, win_y_lo, win_x_hi, win_y_hi;
  longint first_x[NumStages], first_y[NumStages];
  longint prev_x[NumStages], prev_y[NumStages];
  bit     seen_first[NumStages];
  bit     held_ok;
  longint held_x, held_y;

  function automatic void emit(longint x, longint y, bit last, bit empty);
    clip_vertex_t v;
    v.x = x[15:0];
    v.y = y[15:0];
    v.last = last;
    v.empty = empty;
    clipped_q.push_back(v);
  endfunction

  function automatic void put_vertex(longint x, longint y);
    if (held_ok) emit(held_x, held_y, 1'b0, 1'b0);
    held_x = x;
    held_y = y;
    held_ok = 1'b1;
  endfunction

  function automatic bit inside_win(int s, longint x, longint y);
    case (s)
      0: return x >= win_x_lo;
      1: return y >= win_y_lo;
      2: return x <= win_x_hi;
      default: return y <= win_y_hi;
    endcase
  endfunction

  // Other coordinate where the edge meets a = b, exact and truncated toward zero.
  function automatic longint cross_at(longint a1, longint o1, longint a2, longint o2,
                                      longint b);
    longint da, t, dob, mda, mt, mdob, q, r, base;
    bit neg;
    da = a2 - a1;
    t = b - a1;
    dob = o2 - o1;
    if (da == 0 || t == 0 || dob == 0) return o1;
    neg = ((dob < 0) != (t < 0)) != (da < 0);
    mda = da < 0 ? -da : da;
    mt = t < 0 ? -t : t;
    mdob = dob < 0 ? -dob : dob;
    if (mt > mda) mt = mda;
    q = (mdob * mt) / mda;
    r = (mdob * mt) % mda;
    base = neg ? o1 - q : o1 + q;
    if (r != 0) begin
      if (!neg && base < 0) base += 1;
      if (neg && base > 0) base -= 1;
    end
    return base;
  endfunction

  function automatic int cut_edge(int s, longint x1, longint y1, longint x2, longint y2,
                                  output longint ex[2], output longint ey[2]);
    bit in1, in2;
    int n;
    longint b;
    in1 = inside_win(s, x1, y1);
    in2 = inside_win(s, x2, y2);
    n = 0;
    ex[0] = 0; ey[0] = 0; ex[1] = 0; ey[1] = 0;
    if (in1 != in2) begin
      if (s == 0 || s == 2) begin
        b = (s == 0) ? win_x_lo : win_x_hi;
        ex[n] = b;
        ey[n] = cross_at(x1, y1, x2, y2, b);
      end else begin
        b = (s == 1) ? win_y_lo : win_y_hi;
        ex[n] = cross_at(y1, x1, y2, x2, b);
        ey[n] = b;
      end
      n++;
    end
    if (in2) begin
      ex[n] = x2;
      ey[n] = y2;
      n++;
    end
    return n;
  endfunction

  function automatic void pass_to(int s, longint x, longint y);
    longint ex[2], ey[2];
    int n;
    if (s >= NumStages) begin
      put_vertex(x, y);
      return;
    end
    if (!seen_first[s]) begin
      first_x[s] = x; first_y[s] = y;
      prev_x[s] = x; prev_y[s] = y;
      seen_first[s] = 1'b1;
      return;
    end
    n = cut_edge(s, prev_x[s], prev_y[s], x, y, ex, ey);
    prev_x[s] = x;
    prev_y[s] = y;
    for (int i = 0; i < n; i++) pass_to(s + 1, ex[i], ey[i]);
  endfunction

  function automatic void take_vertex(longint x, longint y, bit fin);
    longint ex[2], ey[2];
    int n;
    pass_to(0, x, y);
    if (fin) begin
      // close each stage with its last -> first edge, in order down the row
      for (int s = 0; s < NumStages; s++) begin
        if (seen_first[s]) begin
          n = cut_edge(s, prev_x[s], prev_y[s], first_x[s], first_y[s], ex, ey);
          seen_first[s] = 1'b0;
          for (int i = 0; i < n; i++) pass_to(s + 1, ex[i], ey[i]);
        end
      end
      if (held_ok) emit(held_x, held_y, 1'b1, 1'b0);
      else emit(0, 0, 1'b1, 1'b1);
      held_ok = 1'b0;
    end
  endfunction

  always @(posedge clk) begin
    clip_vertex_t want;
    if (!rst_n) begin
      win_x_lo = ResetLow; win_y_lo = ResetLow;
      win_x_hi = ResetHigh; win_y_hi = ResetHigh;
      for (int s = 0; s < NumStages; s++) seen_first[s] = 1'b0;
      held_ok = 1'b0;
      clipped_q.delete();
      fail_count <= 0;
      vertices_taken <= 0;
      results_taken <= 0;
      empty_results <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_X_MIN: win_x_lo = $signed(cfg.data[15:0]);
          REG_Y_MIN: win_y_lo = $signed(cfg.data[15:0]);
          REG_X_MAX: win_x_hi = $signed(cfg.data[15:0]);
          REG_Y_MAX: win_y_hi = $signed(cfg.data[15:0]);
          default: ;
        endcase
      end
      if (vtx.valid && vtx.ready) begin
        take_vertex(vtx.vert_x, vtx.vert_y, vtx.final_vertex);
        vertices_taken <= vertices_taken + 1;
      end
      if (res.valid && res.ready) begin
        results_taken <= results_taken + 1;
        if (res.all_clipped) empty_results <= empty_results + 1;
        if (clipped_q.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected result x=%0d y=%0d last=%0b empty=%0b", $realtime,
                     res.out_x, res.out_y, res.out_last, res.all_clipped);
          fail_count <= fail_count + 1;
        end else begin
          want = clipped_q.pop_front();
          if (res.out_x !== want.x || res.out_y !== want.y ||
              res.out_last !== want.last || res.all_clipped !== want.empty) begin
            if (fail_count < 10)
              $display("%0t: mismatch exp x=%0d y=%0d last=%0b empty=%0b, got x=%0d y=%0d last=%0b empty=%0b",
                       $realtime, want.x, want.y, want.last, want.empty,
                       res.out_x, res.out_y, res.out_last, res.all_clipped);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    expected_left <= clipped_q.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top: drives vertices and window writes into the clipper and gives the verdict.
`timescale 1ns / 1ps
module tb;
  import pcr_pkg::*;

  localparam int IdleLimit  = 5000;  // cycles with no transaction before giving up
  localparam int DrainWait  = 150;   // settling wait after the checker's queue empties
  localparam int LongHold   = 400;

  logic clk;
  logic rst_n;

  pcr_vtx_if #(16)    vtx ();
  pcr_res_if #(16)    res ();
  pcr_cfg_if #(16, 3) cfg ();

  int fail_count, expected_left, vertices_taken, results_taken, empty_results;
  int send_idle_pct, recv_stall_pct;
  int hold_left, idle_cycles;
  bit hold_start;
  int win_lo_x, win_lo_y, win_hi_x, win_hi_y;

  polygon_clip_to_rectangle #(.COORD_BITS(16)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vtx (vtx),
    .out_res(res),
    .cfg_wr (cfg)
  );

  pcr_clip_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .vtx           (vtx),
    .res           (res),
    .cfg           (cfg),
    .fail_count    (fail_count),
    .expected_left (expected_left),
    .vertices_taken(vertices_taken),
    .results_taken (results_taken),
    .empty_results (empty_results)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Result side: random stalls, plus a long hold-off counted here when requested.
  always @(negedge clk) begin
    if (hold_start) begin
      hold_start = 1'b0;
      hold_left = LongHold;
    end
    if (hold_left > 0) begin
      hold_left--;
      res.ready <= 1'b0;
    end else begin
      res.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: count cycles in which no transaction moves on any channel.
  always @(posedge clk) begin
    if (!rst_n || (vtx.valid && vtx.ready) || (res.valid && res.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout: no transaction for %0d cycles", IdleLimit);
        $display("tb failed");
        $finish;
      end
    end
  end

  // Offer one vertex, with a random gap before it, and hold it until taken.
  task automatic send_vertex(int x, int y, bit fin);
    while ($urandom_range(99) < send_idle_pct) begin
      vtx.valid <= 1'b0;
      @(negedge clk);
    end
    vtx.valid <= 1'b1;
    vtx.vert_x <= x[15:0];
    vtx.vert_y <= y[15:0];
    vtx.final_vertex <= fin;
    do @(posedge clk); while (!vtx.ready);
    @(negedge clk);
  endtask

  task automatic drain();
    vtx.valid <= 1'b0;
    @(negedge clk);
    wait (expected_left == 0);
    repeat (DrainWait) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, int value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value[15:0];
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic set_window(int xl, int yl, int xh, int yh);
    write_reg(REG_X_MIN, xl);
    write_reg(REG_Y_MIN, yl);
    write_reg(REG_X_MAX, xh);
    write_reg(REG_Y_MAX, yh);
    win_lo_x = xl; win_lo_y = yl; win_hi_x = xh; win_hi_y = yh;
  endtask

  // Mostly near the window so edges cross its sides; sometimes anywhere.
  function automatic int pick_coord(int a, int b);
    int lo, hi, v;
    if ($urandom_range(7) == 0) return $signed(16'($urandom()));
    lo = (a < b ? a : b) - 120;
    hi = (a < b ? b : a) + 120;
    v = lo + int'($urandom_range(hi - lo));
    if (v < -32768) v = -32768;
    if (v > 32767) v = 32767;
    return v;
  endfunction

  task automatic random_polygons(int count);
    int n, sent;
    sent = 0;
    while (sent < count) begin
      n = $urandom_range(1, 7);
      for (int i = 0; i < n; i++)
        send_vertex(pick_coord(win_lo_x, win_hi_x), pick_coord(win_lo_y, win_hi_y),
                    i == n - 1);
      sent += n;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    vtx.valid = 1'b0;
    vtx.vert_x = '0;
    vtx.vert_y = '0;
    vtx.final_vertex = 1'b0;
    res.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    hold_start = 1'b0;
    hold_left = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    win_lo_x = ResetLow; win_lo_y = ResetLow;
    win_hi_x = ResetHigh; win_hi_y = ResetHigh;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: default window, no idling.
    // square wholly inside
    send_vertex(150, 150, 0); send_vertex(250, 150, 0);
    send_vertex(250, 250, 0); send_vertex(150, 250, 1);
    // triangle wholly outside: empty result
    send_vertex(0, 0, 0); send_vertex(50, 0, 0); send_vertex(50, 50, 1);
    // lone vertex inside, then outside
    send_vertex(200, 200, 1);
    send_vertex(-5, 400, 1);
    // square around the window, crossing every side
    send_vertex(0, 0, 0); send_vertex(400, 0, 0);
    send_vertex(400, 400, 0); send_vertex(0, 400, 1);
    // extreme coordinates
    send_vertex(-32768, -32768, 0); send_vertex(32767, -32768, 0);
    send_vertex(0, 32767, 1);
    // an edge lying on the left boundary
    send_vertex(100, 50, 0); send_vertex(100, 350, 0); send_vertex(300, 300, 1);
    // diamond with crossings that do not divide evenly
    send_vertex(200, 7, 0); send_vertex(397, 200, 0);
    send_vertex(200, 401, 0); send_vertex(3, 200, 1);
    drain();

    // Random phases through several windows and idling mixes.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_window(-32768, -32768, 32767, 32767);
        1: set_window(300, 300, 100, 100);  // inverted: everything clipped
        2: set_window(-50, -200, 250, 120);
        3: set_window(0, 0, 0, 0);
        4: set_window(32767, -32768, 32767, -32768);
        default: set_window(ResetLow, ResetLow, ResetHigh, ResetHigh);
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      // long output hold-off while vertices keep coming, so the row backs up
      if (ph == 5) begin
        send_idle_pct = 0;
        hold_start = 1'b1;
      end
      random_polygons(ph == 0 || ph == 5 ? 30 : 22);
      drain();
    end

    $display("covered %0d vertices and %0d clipped results (%0d empty) over seven windows",
             vertices_taken, results_taken, empty_results);
    $display("idling mixes from none to 58%% on each side, plus a %0d-cycle output hold-off",
             LongHold);
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
